### rtl/mzfsc_pkg.sv
package mzfsc_pkg;

    // zone count range 1..4, readings carry a 2-bit zone index
    localparam int ZONE_COUNT_DEFAULT = 4;
    localparam int ZONE_W             = 2;
    localparam int TEMP_W             = 12;
    localparam int WIDE_TEMP_W        = 16;
    localparam int SPEED_W            = 7;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 64;

    typedef logic signed [TEMP_W-1:0]      temp_t;
    typedef logic signed [WIDE_TEMP_W-1:0] wide_temp_t;
    typedef logic        [SPEED_W-1:0]     speed_t;
    typedef logic        [63:0]            limits_t;
    typedef logic        [20:0]            levels_t;
    typedef logic        [31:0]            fsh_t;
    typedef logic        [2:0]             mode_t;
    typedef logic        [1:0]             status_t;
    typedef logic        [ZONE_W-1:0]      zone_t;
    typedef logic        [CFG_INDEX_W-1:0] cfg_index_t;

    // register indexes on the write port
    localparam cfg_index_t REG_ZONE0_LIMITS = 3'd0;
    localparam cfg_index_t REG_COOLING_MODE = 3'd4;
    localparam cfg_index_t REG_MANUAL_SPEED = 3'd5;
    localparam cfg_index_t REG_FAN_LEVELS   = 3'd6;
    localparam cfg_index_t REG_FAILSAFE_HYS = 3'd7;

    // cooling modes
    localparam mode_t MODE_OFF        = 3'd0;
    localparam mode_t MODE_PASSIVE    = 3'd1;
    localparam mode_t MODE_AUTO       = 3'd2;
    localparam mode_t MODE_AGGRESSIVE = 3'd3;
    localparam mode_t MODE_MANUAL     = 3'd4;

    // thermal status codes
    localparam status_t STATUS_NORMAL   = 2'd0;
    localparam status_t STATUS_WARNING  = 2'd1;
    localparam status_t STATUS_CRITICAL = 2'd2;
    localparam status_t STATUS_SHUTDOWN = 2'd3;

    // register reset values
    localparam limits_t LIMITS_RESET = 64'h0258_01F4_0190_012C;
    localparam mode_t   MODE_RESET   = MODE_AUTO;
    localparam speed_t  MANUAL_RESET = 7'd0;
    localparam levels_t LEVELS_RESET = 21'd1646110;
    localparam fsh_t    FSH_RESET    = 32'd3277800;

    localparam wide_temp_t START_MAX = -16'sd1000;
    localparam speed_t     SPEED_CAP = 7'd100;
    localparam temp_t      SHOWN_MAX = 12'sd2047;
    localparam temp_t      SHOWN_MIN = -12'sd2048;

    function automatic speed_t cap100(input speed_t v);
        return (v > SPEED_CAP) ? SPEED_CAP : v;
    endfunction

    // threshold k of a packed limits word: 0 low, 1 medium, 2 high, 3 critical
    function automatic wide_temp_t limit_of(input limits_t l, input int k);
        return wide_temp_t'(l[16*k +: 16]);
    endfunction

endpackage

### rtl/mzfsc_if.sv
interface mzfsc_reading_if import mzfsc_pkg::*; ();
    logic  valid;
    logic  ready;
    zone_t zone;
    temp_t temperature;
    logic  sensor_ok;
    logic  last_of_scan;

    modport source (output valid, zone, temperature, sensor_ok, last_of_scan, input ready);
    modport sink   (input valid, zone, temperature, sensor_ok, last_of_scan, output ready);
endinterface

interface mzfsc_result_if import mzfsc_pkg::*; ();
    logic    valid;
    logic    ready;
    speed_t  fan_speed;
    status_t thermal_status;
    zone_t   hottest_zone;
    temp_t   max_temperature;
    logic    shutdown_required;
    logic    status_changed;

    modport source (output valid, fan_speed, thermal_status, hottest_zone, max_temperature,
                    shutdown_required, status_changed, input ready);
    modport sink   (input valid, fan_speed, thermal_status, hottest_zone, max_temperature,
                    shutdown_required, status_changed, output ready);
endinterface

### rtl/multi_zone_fan_speed_controller_core.sv
// Multi-zone fan speed controller. Each transfer on the reading channel is one
// zone temperature in tenths of a degree; a failed sensor read is replaced by
// the fail-safe temperature. Readings pass through an input register and are
// folded into the running scan state (hottest zone, highest fan level needed)
// in the following cycle; the reading marked last_of_scan also loads the result
// register with fan speed, thermal status, hottest zone and maximum temperature.
// One reading is taken per cycle unless stalled; the result register loads as the
// closing reading leaves the input register. Only a closing reading waits, and
// only while the result register holds a result not yet taken. The user must write
// registers with wr_en only while no reading is in flight; the block does not check.
module multi_zone_fan_speed_controller_core
    import mzfsc_pkg::*;
#(
    parameter int ZONE_COUNT = ZONE_COUNT_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  cfg_index_t            wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    mzfsc_reading_if.sink         reading,
    mzfsc_result_if.source        result
);

    // configuration registers
    limits_t zone_limits_reg [ZONE_COUNT];
    mode_t   cooling_mode_reg;
    speed_t  manual_speed_reg;
    levels_t fan_levels_reg;
    fsh_t    fsh_reg;

    // input register
    logic  s1_valid_reg;
    zone_t s1_zone_reg;
    temp_t s1_temp_reg;
    logic  s1_ok_reg;
    logic  s1_last_reg;

    // scan state
    wide_temp_t run_max_reg;
    zone_t      run_hottest_reg;
    speed_t     run_required_reg;
    speed_t     current_speed_reg;
    status_t    current_status_reg;

    // result register
    logic    out_valid_reg;
    speed_t  out_speed_reg;
    status_t out_status_reg;
    zone_t   out_zone_reg;
    temp_t   out_max_reg;
    logic    out_shutdown_reg;
    logic    out_changed_reg;

    logic advance;
    logic load_result;

    // handshake
    assign advance     = s1_valid_reg
                       && (!s1_last_reg || !out_valid_reg || result.ready);
    assign load_result = advance && s1_last_reg;
    assign reading.ready = !s1_valid_reg || advance;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ZONE_COUNT; i++)
            begin
                zone_limits_reg[i] <= LIMITS_RESET;
            end
            cooling_mode_reg <= MODE_RESET;
            manual_speed_reg <= MANUAL_RESET;
            fan_levels_reg   <= LEVELS_RESET;
            fsh_reg          <= FSH_RESET;
        end
        else if (wr_en)
        begin
            for (int i = 0; i < ZONE_COUNT; i++)
            begin
                if (wr_index == REG_ZONE0_LIMITS + cfg_index_t'(i))
                begin
                    zone_limits_reg[i] <= wr_data;
                end
            end
            if (wr_index == REG_COOLING_MODE)
            begin
                cooling_mode_reg <= wr_data[2:0];
            end
            if (wr_index == REG_MANUAL_SPEED)
            begin
                manual_speed_reg <= wr_data[SPEED_W-1:0];
            end
            if (wr_index == REG_FAN_LEVELS)
            begin
                fan_levels_reg <= wr_data[20:0];
            end
            if (wr_index == REG_FAILSAFE_HYS)
            begin
                fsh_reg <= wr_data[31:0];
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (reading.ready)
        begin
            s1_valid_reg <= reading.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (reading.valid && reading.ready)
        begin
            s1_zone_reg <= reading.zone;
            s1_temp_reg <= reading.temperature;
            s1_ok_reg   <= reading.sensor_ok;
            s1_last_reg <= reading.last_of_scan;
        end
    end

    // fan levels, saturated
    speed_t lvl_min, lvl_med, lvl_max;
    assign lvl_min = cap100(fan_levels_reg[6:0]);
    assign lvl_med = cap100(fan_levels_reg[13:7]);
    assign lvl_max = cap100(fan_levels_reg[20:14]);

    // per-reading update
    logic                    in_range;
    wide_temp_t              temp_eff;
    limits_t                 zone_lim;
    logic [15:0]             hyst;
    logic signed [17:0]      temp_x;
    logic signed [17:0]      thr_x [4];
    speed_t                  need;
    wide_temp_t              run_max_next;
    zone_t                   run_hottest_next;
    speed_t                  run_required_next;

    always_comb
    begin
        in_range = {1'b0, s1_zone_reg} < 3'(ZONE_COUNT);
        temp_eff = s1_ok_reg ? wide_temp_t'(s1_temp_reg) : wide_temp_t'(fsh_reg[15:0]);

        zone_lim = LIMITS_RESET;
        for (int i = 0; i < ZONE_COUNT; i++)
        begin
            if (s1_zone_reg == zone_t'(i))
            begin
                zone_lim = zone_limits_reg[i];
            end
        end

        hyst   = (current_speed_reg >= lvl_max) ? fsh_reg[31:16] : 16'd0;
        temp_x = 18'(temp_eff);
        for (int k = 0; k < 4; k++)
        begin
            thr_x[k] = 18'(limit_of(zone_lim, k)) - $signed({2'b00, hyst});
        end

        // critical reading asks for the max level like a high one
        priority if (temp_x >= thr_x[3] || temp_x >= thr_x[2])
        begin
            need = lvl_max;
        end
        else if (temp_x >= thr_x[1])
        begin
            need = lvl_med;
        end
        else if (temp_x >= thr_x[0])
        begin
            need = lvl_min;
        end
        else
        begin
            need = '0;
        end

        run_max_next      = run_max_reg;
        run_hottest_next  = run_hottest_reg;
        run_required_next = run_required_reg;
        if (in_range)
        begin
            // ties keep the earlier zone
            if (temp_eff > run_max_reg)
            begin
                run_max_next     = temp_eff;
                run_hottest_next = s1_zone_reg;
            end
            if (need > run_required_reg)
            begin
                run_required_next = need;
            end
        end
    end

    // scan close: status from the hottest zone, speed by mode
    limits_t hot_lim;
    status_t status_next;
    speed_t  speed_next;
    temp_t   shown;

    always_comb
    begin
        hot_lim = LIMITS_RESET;
        for (int i = 0; i < ZONE_COUNT; i++)
        begin
            if (run_hottest_next == zone_t'(i))
            begin
                hot_lim = zone_limits_reg[i];
            end
        end

        priority if (run_max_next >= limit_of(hot_lim, 3))
        begin
            status_next = STATUS_SHUTDOWN;
        end
        else if (run_max_next >= limit_of(hot_lim, 2))
        begin
            status_next = STATUS_CRITICAL;
        end
        else if (run_max_next >= limit_of(hot_lim, 1))
        begin
            status_next = STATUS_WARNING;
        end
        else
        begin
            status_next = STATUS_NORMAL;
        end

        unique case (cooling_mode_reg)
            MODE_OFF:        speed_next = '0;
            MODE_PASSIVE:    speed_next = lvl_min;
            MODE_AUTO:       speed_next = cap100(run_required_next);
            MODE_AGGRESSIVE: speed_next = lvl_max;
            MODE_MANUAL:     speed_next = cap100(manual_speed_reg);
            default:         speed_next = current_speed_reg;
        endcase

        // saturate to the 12-bit field
        if (run_max_next > wide_temp_t'(SHOWN_MAX))
        begin
            shown = SHOWN_MAX;
        end
        else if (run_max_next < wide_temp_t'(SHOWN_MIN))
        begin
            shown = SHOWN_MIN;
        end
        else
        begin
            shown = run_max_next[TEMP_W-1:0];
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_max_reg        <= START_MAX;
            run_hottest_reg    <= '0;
            run_required_reg   <= '0;
            current_speed_reg  <= '0;
            current_status_reg <= STATUS_NORMAL;
        end
        else if (advance)
        begin
            if (s1_last_reg)
            begin
                run_max_reg        <= START_MAX;
                run_hottest_reg    <= '0;
                run_required_reg   <= '0;
                current_speed_reg  <= speed_next;
                current_status_reg <= status_next;
            end
            else
            begin
                run_max_reg      <= run_max_next;
                run_hottest_reg  <= run_hottest_next;
                run_required_reg <= run_required_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_speed_reg    <= speed_next;
            out_status_reg   <= status_next;
            out_zone_reg     <= run_hottest_next;
            out_max_reg      <= shown;
            out_shutdown_reg <= (status_next == STATUS_SHUTDOWN);
            out_changed_reg  <= (status_next != current_status_reg);
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.fan_speed         = out_speed_reg;
    assign result.thermal_status    = out_status_reg;
    assign result.hottest_zone      = out_zone_reg;
    assign result.max_temperature   = out_max_reg;
    assign result.shutdown_required = out_shutdown_reg;
    assign result.status_changed    = out_changed_reg;

    // checks
    a_speed_capped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_speed_reg <= SPEED_CAP)
        else $error("fan speed above cap");

    a_shutdown_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_shutdown_reg == (out_status_reg == STATUS_SHUTDOWN)))
        else $error("shutdown flag disagrees with status");

    a_stall_only_on_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        !reading.ready |-> (s1_valid_reg && s1_last_reg && out_valid_reg))
        else $error("reading channel stalled without a pending result");

    a_status_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> (current_status_reg == out_status_reg
                         && current_speed_reg == out_speed_reg))
        else $error("scan state does not match delivered result");

    a_scan_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> (run_max_reg == START_MAX && run_required_reg == '0))
        else $error("running scan state not cleared after scan close");

endmodule

### tb/multi_zone_fan_speed_controller_core_tb.sv
module multi_zone_fan_speed_controller_core_tb;
    import mzfsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // cooling mode codes with no defined behaviour, the fan speed is held
    localparam mode_t MODE_SPARE_LO = 3'd5;
    localparam mode_t MODE_SPARE_HI = 3'd7;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 110;
    localparam int SETTLE      = 4;

    typedef struct {
        zone_t zone;
        temp_t temperature;
        logic  sensor_ok;
        logic  last_of_scan;
    } zone_reading_t;

    typedef struct {
        speed_t  fan_speed;
        status_t thermal_status;
        zone_t   hottest_zone;
        temp_t   max_temperature;
        logic    shutdown_required;
        logic    status_changed;
    } fan_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    cfg_index_t            wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    mzfsc_reading_if reading_bus ();
    mzfsc_result_if  result_bus ();

    multi_zone_fan_speed_controller_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .reading  (reading_bus.sink),
        .result   (result_bus.source)
    );

    // register copies kept alongside the block
    limits_t zone_limit_regs [ZONE_COUNT_DEFAULT];
    mode_t   mode_reg;
    speed_t  manual_reg;
    levels_t levels_reg;
    fsh_t    fsh_reg;

    // scan state as the block should hold it
    int      scan_max;
    zone_t   scan_hottest;
    int      scan_need;
    int      fan_now;
    status_t status_now;
    logic    shutdown_now;

    zone_reading_t queued_readings [$];
    fan_report_t   awaited_reports [$];
    zone_reading_t drive_item;
    zone_reading_t seen_reading;
    fan_report_t   want_report;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;

    function automatic int pct_cap(input int v);
        return (v > int'(SPEED_CAP)) ? int'(SPEED_CAP) : v;
    endfunction

    // threshold k of a zone: 0 low, 1 medium, 2 high, 3 critical
    function automatic int limit_at(input zone_t z, input int k);
        return int'($signed(zone_limit_regs[z][16*k +: 16]));
    endfunction

    function automatic int level_pct(input int k);
        return pct_cap(int'(levels_reg[7*k +: 7]));
    endfunction

    // fold one accepted reading into the scan, closing it on last_of_scan
    task automatic fold_reading(input zone_reading_t r);
        int          t;
        int          hyst;
        int          need;
        int          shown;
        zone_t       hz;
        status_t     st;
        fan_report_t rep;
        t = r.sensor_ok ? int'(r.temperature) : int'($signed(fsh_reg[15:0]));
        if (int'(r.zone) < ZONE_COUNT_DEFAULT)
        begin
            if (t > scan_max)
            begin
                scan_max     = t;
                scan_hottest = r.zone;
            end
            // thresholds drop by the hysteresis while the fan is at maximum
            hyst = (fan_now >= level_pct(2)) ? int'(fsh_reg[31:16]) : 0;
            if (t >= limit_at(r.zone, 3) - hyst || t >= limit_at(r.zone, 2) - hyst)
                need = level_pct(2);
            else if (t >= limit_at(r.zone, 1) - hyst)
                need = level_pct(1);
            else if (t >= limit_at(r.zone, 0) - hyst)
                need = level_pct(0);
            else
                need = 0;
            if (need > scan_need)
                scan_need = need;
        end
        if (r.last_of_scan)
        begin
            // status from the hottest zone's own thresholds
            hz = scan_hottest;
            if (scan_max >= limit_at(hz, 3))
            begin
                st           = STATUS_SHUTDOWN;
                shutdown_now = 1'b1;
            end
            else
            begin
                shutdown_now = 1'b0;
                if (scan_max >= limit_at(hz, 2))
                    st = STATUS_CRITICAL;
                else if (scan_max >= limit_at(hz, 1))
                    st = STATUS_WARNING;
                else
                    st = STATUS_NORMAL;
            end
            rep.status_changed = (st != status_now);
            status_now         = st;
            case (mode_reg)
                MODE_OFF:        fan_now = 0;
                MODE_PASSIVE:    fan_now = level_pct(0);
                MODE_AUTO:       fan_now = pct_cap(scan_need);
                MODE_AGGRESSIVE: fan_now = level_pct(2);
                MODE_MANUAL:     fan_now = pct_cap(int'(manual_reg));
                default:         ;
            endcase
            shown = scan_max;
            if (shown > int'(SHOWN_MAX))
                shown = int'(SHOWN_MAX);
            else if (shown < int'(SHOWN_MIN))
                shown = int'(SHOWN_MIN);
            rep.fan_speed         = speed_t'(fan_now);
            rep.thermal_status    = st;
            rep.hottest_zone      = hz;
            rep.max_temperature   = temp_t'(shown);
            rep.shutdown_required = shutdown_now;
            awaited_reports.push_back(rep);
            // next scan starts afresh
            scan_max     = int'(START_MAX);
            scan_hottest = '0;
            scan_need    = 0;
        end
    endtask

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic push_reading(input zone_t z, input int t, input logic ok, input logic last);
        zone_reading_t r;
        r.zone         = z;
        r.temperature  = temp_t'(t);
        r.sensor_ok    = ok;
        r.last_of_scan = last;
        queued_readings.push_back(r);
    endtask

    // register write on the plain port, mirrored into the local copies
    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        case (idx)
            REG_COOLING_MODE: mode_reg   = value[2:0];
            REG_MANUAL_SPEED: manual_reg = value[6:0];
            REG_FAN_LEVELS:   levels_reg = value[20:0];
            REG_FAILSAFE_HYS: fsh_reg    = value[31:0];
            default:          zone_limit_regs[idx[1:0]] = value;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // wait for every reading to go in and every report to come out
    task automatic wait_drained();
        do
            @(negedge clk);
        while (queued_readings.size() != 0 || reading_bus.valid);
        while (awaited_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // temperatures biased towards the zone's thresholds and the field extremes
    function automatic int pick_temperature(input zone_t z);
        int t;
        case ($urandom_range(9))
            0:       t = int'(SHOWN_MIN);
            1:       t = int'(SHOWN_MAX);
            2, 3, 4, 5:
            begin
                t = limit_at(z, int'($urandom_range(3))) + int'($urandom_range(60)) - 30;
                if ($urandom_range(1))
                    t = t - int'(fsh_reg[31:16]);
            end
            default: t = int'($urandom_range(4095)) - 2048;
        endcase
        if (t > int'(SHOWN_MAX))
            t = int'(SHOWN_MAX);
        else if (t < int'(SHOWN_MIN))
            t = int'(SHOWN_MIN);
        return t;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // reading driver
    always @(posedge clk)
    begin
        if (rst_n && (!reading_bus.valid || reading_bus.ready))
        begin
            if (queued_readings.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drive_item = queued_readings.pop_front();
                reading_bus.valid        <= 1'b1;
                reading_bus.zone         <= drive_item.zone;
                reading_bus.temperature  <= drive_item.temperature;
                reading_bus.sensor_ok    <= drive_item.sensor_ok;
                reading_bus.last_of_scan <= drive_item.last_of_scan;
            end
            else
                reading_bus.valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // accepted readings feed the scan prediction
    always @(posedge clk)
    begin
        if (rst_n && reading_bus.valid && reading_bus.ready)
        begin
            seen_reading.zone         = reading_bus.zone;
            seen_reading.temperature  = reading_bus.temperature;
            seen_reading.sensor_ok    = reading_bus.sensor_ok;
            seen_reading.last_of_scan = reading_bus.last_of_scan;
            fold_reading(seen_reading);
        end
    end

    // result transfer checked against the oldest awaited report
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (awaited_reports.size() == 0)
            begin
                $display("%0t: report with no scan awaiting, actual fan %0d status %0d zone %0d max %0d",
                         $time, result_bus.fan_speed, result_bus.thermal_status,
                         result_bus.hottest_zone, result_bus.max_temperature);
                mismatch_count++;
            end
            else
            begin
                want_report = awaited_reports.pop_front();
                check_field("fan_speed", want_report.fan_speed, result_bus.fan_speed);
                check_field("thermal_status", want_report.thermal_status,
                            result_bus.thermal_status);
                check_field("hottest_zone", want_report.hottest_zone, result_bus.hottest_zone);
                check_field("max_temperature", want_report.max_temperature,
                            result_bus.max_temperature);
                check_field("shutdown_required", want_report.shutdown_required,
                            result_bus.shutdown_required);
                check_field("status_changed", want_report.status_changed,
                            result_bus.status_changed);
            end
        end
    end

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int      p;
        int      i;
        int      k;
        int      base;
        int      scan_len;
        int      phase_items;
        bit      paused;
        zone_t   z;
        limits_t plan_limits [ZONE_COUNT_DEFAULT];
        mode_t   plan_mode;
        speed_t  plan_manual;
        levels_t plan_levels;
        fsh_t    plan_fsh;

        // known values on every input before the first edge
        rst_n                    = 1'b0;
        wr_en                    = 1'b0;
        wr_index                 = '0;
        wr_data                  = '0;
        reading_bus.valid        = 1'b0;
        reading_bus.zone         = '0;
        reading_bus.temperature  = '0;
        reading_bus.sensor_ok    = 1'b0;
        reading_bus.last_of_scan = 1'b0;
        result_bus.ready         = 1'b0;
        send_idle_pct            = 0;
        recv_stall_pct           = 0;
        mismatch_count           = 0;

        for (i = 0; i < ZONE_COUNT_DEFAULT; i++)
            zone_limit_regs[i] = LIMITS_RESET;
        mode_reg     = MODE_RESET;
        manual_reg   = MANUAL_RESET;
        levels_reg   = LEVELS_RESET;
        fsh_reg      = FSH_RESET;
        scan_max     = int'(START_MAX);
        scan_hottest = '0;
        scan_need    = 0;
        fan_now      = 0;
        status_now   = STATUS_NORMAL;
        shutdown_now = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed scans on the reset settings
        // tie on the top reading keeps the earlier zone
        push_reading(2'd0, 250, 1'b1, 1'b0);
        push_reading(2'd1, 450, 1'b1, 1'b0);
        push_reading(2'd2, 450, 1'b1, 1'b0);
        push_reading(2'd3, 100, 1'b1, 1'b1);
        // nothing above the starting maximum
        push_reading(2'd2, -1500, 1'b1, 1'b1);
        push_reading(2'd0, int'(SHOWN_MIN), 1'b1, 1'b0);
        push_reading(2'd3, int'(SHOWN_MIN), 1'b1, 1'b1);
        // failed sensor takes the fail-safe value, fan goes to maximum
        push_reading(2'd1, 0, 1'b0, 1'b1);
        // fan at maximum so the lowered thresholds apply; repeated zone
        push_reading(2'd0, 460, 1'b1, 1'b0);
        push_reading(2'd0, 470, 1'b1, 1'b1);
        push_reading(2'd3, int'(SHOWN_MAX), 1'b1, 1'b0);
        push_reading(2'd2, int'(SHOWN_MAX), 1'b1, 1'b1);
        push_reading(2'd1, 599, 1'b1, 1'b0);
        push_reading(2'd2, 1365, 1'b0, 1'b0);
        push_reading(2'd3, -1, 1'b1, 1'b1);
        push_reading(2'd2, 300, 1'b1, 1'b0);
        push_reading(2'd1, 399, 1'b1, 1'b1);
        push_reading(2'd0, 0, 1'b1, 1'b1);
        wait_drained();

        for (p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            endcase

            // register settings: extremes first, then random ones
            case (p)
                0:
                begin
                    for (i = 0; i < ZONE_COUNT_DEFAULT; i++)
                        plan_limits[i] = '0;
                    plan_mode   = MODE_OFF;
                    plan_manual = '0;
                    plan_levels = '0;
                    plan_fsh    = '0;
                end
                1:
                begin
                    for (i = 0; i < ZONE_COUNT_DEFAULT; i++)
                        plan_limits[i] = '1;
                    plan_mode   = MODE_SPARE_HI;
                    plan_manual = '1;
                    plan_levels = '1;
                    plan_fsh    = '1;
                end
                2:
                begin
                    for (i = 0; i < ZONE_COUNT_DEFAULT; i++)
                        plan_limits[i] = 64'h8000_8000_8000_8000;
                    plan_mode   = MODE_MANUAL;
                    plan_manual = SPEED_CAP;
                    plan_levels = levels_t'($urandom_range(2097151));
                    plan_fsh    = 32'h0000_7FFF;
                end
                3:
                begin
                    for (i = 0; i < ZONE_COUNT_DEFAULT; i++)
                        plan_limits[i] = 64'h7FFF_7FFF_7FFF_7FFF;
                    plan_mode   = MODE_AGGRESSIVE;
                    plan_manual = SPEED_CAP + 7'd1;
                    plan_levels = {7'd100, 7'd0, 7'd127};
                    plan_fsh    = 32'h8000_8000;
                end
                default:
                begin
                    for (i = 0; i < ZONE_COUNT_DEFAULT; i++)
                    begin
                        case ($urandom_range(3))
                            0, 1:
                            begin
                                // ascending thresholds in the reading range
                                base = int'($urandom_range(1600)) - 400;
                                for (k = 0; k < 4; k++)
                                begin
                                    plan_limits[i][16*k +: 16] = 16'(base);
                                    base = base + int'($urandom_range(300));
                                end
                            end
                            2:
                            begin
                                for (k = 0; k < 4; k++)
                                    plan_limits[i][16*k +: 16] =
                                        16'(int'($urandom_range(2400)) - 600);
                            end
                            default: plan_limits[i] = {$urandom, $urandom};
                        endcase
                    end
                    case (p)
                        4:       plan_mode = MODE_PASSIVE;
                        6:       plan_mode = MODE_SPARE_LO;
                        8:       plan_mode = MODE_MANUAL;
                        default: plan_mode = MODE_AUTO;
                    endcase
                    plan_manual = speed_t'($urandom_range(127));
                    if ($urandom_range(1))
                        plan_levels = levels_t'($urandom_range(2097151));
                    else
                        plan_levels = {7'($urandom_range(100)), 7'($urandom_range(100)),
                                       7'($urandom_range(100))};
                    if ($urandom_range(3) != 0)
                        plan_fsh[15:0] = 16'(int'($urandom_range(2547)) - 500);
                    else
                        plan_fsh[15:0] = 16'($urandom_range(65535));
                    if ($urandom_range(3) != 0)
                        plan_fsh[31:16] = 16'($urandom_range(300));
                    else
                        plan_fsh[31:16] = 16'($urandom_range(65535));
                end
            endcase

            for (i = 0; i < ZONE_COUNT_DEFAULT; i++)
                write_register(REG_ZONE0_LIMITS + cfg_index_t'(i), plan_limits[i]);
            write_register(REG_COOLING_MODE, CFG_DATA_W'(plan_mode));
            write_register(REG_MANUAL_SPEED, CFG_DATA_W'(plan_manual));
            write_register(REG_FAN_LEVELS, CFG_DATA_W'(plan_levels));
            write_register(REG_FAILSAFE_HYS, CFG_DATA_W'(plan_fsh));
            @(negedge clk);

            // mostly whole scans with random content, some stray readings
            phase_items = 0;
            paused      = 1'b0;
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 85)
                begin
                    scan_len = $urandom_range(1, 6);
                    for (i = 0; i < scan_len; i++)
                    begin
                        if ($urandom_range(99) < 60)
                            z = zone_t'(i % ZONE_COUNT_DEFAULT);
                        else
                            z = zone_t'($urandom_range(3));
                        push_reading(z, pick_temperature(z), $urandom_range(99) < 90,
                                     i == scan_len - 1);
                    end
                    phase_items += scan_len;
                end
                else
                begin
                    z = zone_t'($urandom_range(3));
                    push_reading(z, pick_temperature(z), 1'($urandom_range(1)),
                                 $urandom_range(99) < 25);
                    phase_items++;
                end
                // sender holds off until every report is in
                if (!paused && p % 3 == 0 && phase_items >= PHASE_ITEMS / 2)
                begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
